// ----- design/qvr_pkg.sv -----
// Shared widths and types for the quaternion point rotation pipeline.
`default_nettype none

package qvr_pkg;

   localparam int QuatW  = 16;              // Q2.14 quaternion component
   localparam int PtW    = 24;              // Q12.12 point / result component
   localparam int ProdW  = QuatW + PtW;     // q*p partial product
   localparam int TW     = ProdW + 2;       // sum of four q*p products
   localparam int HalfW  = TW / 2;          // split point of t for second multiply
   localparam int LoW    = HalfW + 1 + QuatW;
   localparam int HiW    = (TW - HalfW) + QuatW;
   localparam int TqW    = TW + QuatW;      // full t*q product
   localparam int RW     = TqW + 2;         // sum of four t*q products
   localparam int FracSh = 28;
   localparam int ShW    = RW - FracSh;
   localparam int Stages = 6;

   typedef logic signed [QuatW-1:0] quat_type;
   typedef logic signed [PtW-1:0]   pt_type;
   typedef logic signed [ProdW-1:0] prod_type;
   typedef logic signed [TW-1:0]    t_type;
   typedef logic signed [LoW-1:0]   lo_type;
   typedef logic signed [HiW-1:0]   hi_type;
   typedef logic signed [TqW-1:0]   tq_type;
   typedef logic signed [RW-1:0]    r_type;
   typedef logic signed [ShW-1:0]   sh_type;

   localparam pt_type SatMax = {1'b0, {(PtW-1){1'b1}}};
   localparam pt_type SatMin = {1'b1, {(PtW-1){1'b0}}};

   // Advance strobes for the two register stages of the split multiplier.
   typedef struct packed {
      logic part;
      logic sum;
   } qvr_adv_type;

endpackage

`default_nettype wire

// ----- design/qvr_if.sv -----
// Request and response channel interfaces for the rotation pipeline.
`default_nettype none

interface qvr_req_if import qvr_pkg::*; ();
   logic     valid;
   logic     ready;
   quat_type quat_x;
   quat_type quat_y;
   quat_type quat_z;
   quat_type quat_w;
   pt_type   pt_x;
   pt_type   pt_y;
   pt_type   pt_z;
   pt_type   pt_w;

   modport source (output valid, quat_x, quat_y, quat_z, quat_w,
                   pt_x, pt_y, pt_z, pt_w, input ready);
   modport sink   (input valid, quat_x, quat_y, quat_z, quat_w,
                   pt_x, pt_y, pt_z, pt_w, output ready);
endinterface

interface qvr_rsp_if import qvr_pkg::*; ();
   logic   valid;
   logic   ready;
   pt_type rot_x;
   pt_type rot_y;
   pt_type rot_z;
   pt_type rot_w;

   modport source (output valid, rot_x, rot_y, rot_z, rot_w, input ready);
   modport sink   (input valid, rot_x, rot_y, rot_z, rot_w, output ready);
endinterface

`default_nettype wire

// ----- design/qvr_wide_mul.sv -----
// Two-stage split multiplier: 42-bit signed t times 16-bit signed q.
`default_nettype none

module qvr_wide_mul import qvr_pkg::*; (
   input  wire         clock,
   input  qvr_adv_type adv,
   input  t_type       t_val,
   input  quat_type    q_val,
   output tq_type      prod
);

   lo_type lo_in, lo_ff;
   hi_type hi_in, hi_ff;
   tq_type prod_in, prod_ff;

   always_comb begin
      // low half is unsigned, high half carries the sign
      lo_in   = lo_type'($signed({1'b0, t_val[HalfW-1:0]})) * lo_type'(q_val);
      hi_in   = hi_type'($signed(t_val[TW-1:HalfW])) * hi_type'(q_val);
      prod_in = (tq_type'(hi_ff) <<< HalfW) + tq_type'(lo_ff);
   end

   always_ff @(posedge clock) begin
      if (adv.part) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (adv.sum) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ----- design/quaternion_vector_rotation.sv -----
// Top level: pipelined quaternion point rotation q * p * conj(q).
// A request passes through six register stages before its response is valid.
// Throughput: one item per cycle; each stage holds independently, so bubbles
// close up under a response stall and requests keep flowing until all six
// stages are full. Depth is set by the two multiply passes and the wide sums.
// Reset clears every stage valid bit; payload registers are not reset.
`default_nettype none

module quaternion_vector_rotation import qvr_pkg::*; (
   input wire        clock,
   input wire        reset,
   qvr_req_if.sink   req_chan,
   qvr_rsp_if.source rsp_chan
);

   logic [Stages-1:0] v_ff, v_in, en;

   quat_type q [4];
   pt_type   p [4];
   prod_type qp_in [4][4];
   prod_type qp_ff [4][4];
   t_type    t_in [4];
   t_type    t_ff [4];
   quat_type q2_ff [4];
   quat_type q1_ff [4];
   tq_type   tq [4][4];
   r_type    r_in [4];
   r_type    r_ff [4];
   pt_type   rot_in [4];
   pt_type   rot_ff [4];
   sh_type   sh [4];
   qvr_adv_type adv;

   // stage k may load when empty or when its contents move on
   always_comb begin
      en[Stages-1] = !v_ff[Stages-1] || rsp_chan.ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = req_chan.valid;
      for (int k = 1; k < Stages; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   assign req_chan.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < Stages; k++) begin
            if (en[k]) v_ff[k] <= v_in[k];
         end
      end
   end

   // stage 1: sixteen q*p products
   always_comb begin
      q[0] = req_chan.quat_x;
      q[1] = req_chan.quat_y;
      q[2] = req_chan.quat_z;
      q[3] = req_chan.quat_w;
      p[0] = req_chan.pt_x;
      p[1] = req_chan.pt_y;
      p[2] = req_chan.pt_z;
      p[3] = req_chan.pt_w;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            qp_in[i][j] = prod_type'(q[i]) * prod_type'(p[j]);
         end
      end
   end

   // stage 2: t = q * p
   always_comb begin
      t_in[0] = t_type'(qp_ff[3][0]) + t_type'(qp_ff[0][3])
              + t_type'(qp_ff[1][2]) - t_type'(qp_ff[2][1]);
      t_in[1] = t_type'(qp_ff[3][1]) - t_type'(qp_ff[0][2])
              + t_type'(qp_ff[1][3]) + t_type'(qp_ff[2][0]);
      t_in[2] = t_type'(qp_ff[3][2]) + t_type'(qp_ff[0][1])
              - t_type'(qp_ff[1][0]) + t_type'(qp_ff[2][3]);
      t_in[3] = t_type'(qp_ff[3][3]) - t_type'(qp_ff[0][0])
              - t_type'(qp_ff[1][1]) - t_type'(qp_ff[2][2]);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         qp_ff <= qp_in;
         q1_ff <= q;
      end
      if (en[1]) begin
         t_ff  <= t_in;
         q2_ff <= q1_ff;
      end
   end

   // stages 3 and 4: t_i * q_j through the split multipliers
   assign adv.part = en[2];
   assign adv.sum  = en[3];

   for (genvar gi = 0; gi < 4; gi++) begin : g_row
      for (genvar gj = 0; gj < 4; gj++) begin : g_col
         qvr_wide_mul u_mul (
            .clock (clock),
            .adv   (adv),
            .t_val (t_ff[gi]),
            .q_val (q2_ff[gj]),
            .prod  (tq[gi][gj])
         );
      end
   end

   // stage 5: r = t * conj(q), conjugate signs folded into the sums
   always_comb begin
      r_in[0] = - r_type'(tq[3][0]) + r_type'(tq[0][3])
                - r_type'(tq[1][2]) + r_type'(tq[2][1]);
      r_in[1] = - r_type'(tq[3][1]) + r_type'(tq[0][2])
                + r_type'(tq[1][3]) - r_type'(tq[2][0]);
      r_in[2] = - r_type'(tq[3][2]) - r_type'(tq[0][1])
                + r_type'(tq[1][0]) + r_type'(tq[2][3]);
      r_in[3] =   r_type'(tq[3][3]) + r_type'(tq[0][0])
                + r_type'(tq[1][1]) + r_type'(tq[2][2]);
   end

   // stage 6: floor shift and clamp
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sh[i] = sh_type'(r_ff[i] >>> FracSh);
         if (sh[i] > sh_type'(SatMax)) begin
            rot_in[i] = SatMax;
         end else if (sh[i] < sh_type'(SatMin)) begin
            rot_in[i] = SatMin;
         end else begin
            rot_in[i] = sh[i][PtW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) r_ff <= r_in;
      if (en[5]) rot_ff <= rot_in;
   end

   assign rsp_chan.valid = v_ff[Stages-1];
   assign rsp_chan.rot_x = rot_ff[0];
   assign rsp_chan.rot_y = rot_ff[1];
   assign rsp_chan.rot_z = rot_ff[2];
   assign rsp_chan.rot_w = rot_ff[3];

   a_reset_empty: assert property (@(posedge clock) reset |=> v_ff == '0)
      else $error("pipeline not empty after reset");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (&v_ff) && !rsp_chan.ready)
      else $error("request held while a stage is free");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (v_ff[Stages-1] && !rsp_chan.ready) |=> v_ff[Stages-1] && $stable(rot_ff[0]))
      else $error("stalled response lost");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (v_ff[Stages-2] && en[Stages-1]) |=> v_ff[Stages-1])
      else $error("item lost between last two stages");

endmodule

`default_nettype wire
